// ===== rtl/rdb_pkg.sv =====
// shared types, constants and helpers of the rotated dither blitter
// no dependencies
package rdb_pkg;

   localparam int LCD_LINES_DEF           = 144;
   localparam int LCD_PIXELS_PER_LINE_DEF = 160;

   localparam logic       KIND_WRITE     = 1'b0;
   localparam logic       KIND_READ      = 1'b1;

   localparam logic [15:0] CLEAR_MASK    = 16'hE000;
   localparam int          PATTERN_SHIFT = 13;
   localparam logic [2:0]  SPILL_OFFSET  = 3'd6;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_READ,
      ST_READ_WAIT,
      ST_SETUP,
      ST_PIX_RD,
      ST_PIX_WR
   } state_type;

   typedef struct packed {
      logic [1:0] shade;
      logic [2:0] offset;
      logic       second;
   } merge_ctl_type;

   function automatic logic [2:0] shade_pattern(input logic [1:0] shade);
      logic [2:0] pat;
      case (shade)
         2'd0: pat = 3'b000;
         2'd1: pat = 3'b001;
         2'd2: pat = 3'b011;
         2'd3: pat = 3'b111;
         default: pat = 3'b000;
      endcase
      return pat;
   endfunction

endpackage

// ===== rtl/rdb_ram.sv =====
// generic single-port ram with registered read
// no dependencies
module rdb_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 8640
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic                     re,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic [WIDTH-1:0]         wdata,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[addr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem_ff[addr];
      end
   end

   assign rdata = rdata_ff;

endmodule

// ===== rtl/rdb_merge.sv =====
// shared read-modify-write unit: places a 3-dot pattern into one byte
// depends on rdb_pkg
module rdb_merge import rdb_pkg::*; (
   input  merge_ctl_type ctl,
   input  logic [7:0]    rdata,
   output logic [7:0]    wdata
);

   logic [15:0] clr16;
   logic [15:0] set16;
   logic [7:0]  keep;
   logic [7:0]  set8;

   always_comb begin
      clr16 = CLEAR_MASK >> ctl.offset;
      set16 = ({13'd0, shade_pattern(ctl.shade)} << PATTERN_SHIFT) >> ctl.offset;
      if (ctl.second) begin
         keep = ~clr16[7:0];
         set8 = set16[7:0];
      end else begin
         keep = ~clr16[15:8];
         set8 = set16[15:8];
      end
      wdata = (rdata & keep) | set8;
   end

endmodule

// ===== rtl/rotated_dither_blitter_core.sv =====
// top level of the rotated dither blitter: sequencer, framebuffer and merge unit
// depends on rdb_pkg, rdb_ram, rdb_merge
//
//   channel   handshake            payload
//   request   start / busy         req_kind, req_line, req_column_group,
//                                  req_packed_pixels, req_read_address
//   response  rsp_strobe           rsp_read_data
//
// a read passes through ST_READ and ST_READ_WAIT, the result shows in ST_READ_WAIT
// a write goes through ST_SETUP, then ST_PIX_RD and ST_PIX_WR per touched byte and
// ST_PIX_RD per skipped byte: the single ram port does a read and a write per byte
// a write with line out of range is absorbed in the accept cycle
// after reset the framebuffer is zeroed, one byte a cycle: 8640 bytes at default size
// the receiver cannot stall, results are never held
module rotated_dither_blitter_core import rdb_pkg::*; #(
   parameter int LCD_LINES           = LCD_LINES_DEF,
   parameter int LCD_PIXELS_PER_LINE = LCD_PIXELS_PER_LINE_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic        req_kind,
   input  logic [7:0]  req_line,
   input  logic [5:0]  req_column_group,
   input  logic [7:0]  req_packed_pixels,
   input  logic [13:0] req_read_address,
   output logic        rsp_strobe,
   output logic [7:0]  rsp_read_data
);

   localparam int ROW_BYTES   = (LCD_LINES * 3 + 7) / 8;
   localparam int STORE_BYTES = LCD_PIXELS_PER_LINE * ROW_BYTES;
   localparam int ADDR_W      = $clog2(STORE_BYTES);
   localparam int FULL_W      = $clog2(257 * ROW_BYTES + 1);
   localparam int T_W         = $clog2(LCD_LINES * 3);

   state_type         state_ff, state_in;
   logic [ADDR_W-1:0] clr_ff, clr_in;
   logic [13:0]       raddr_ff, raddr_in;
   logic              rd_ok_ff, rd_ok_in;
   logic [7:0]        shades_ff, shades_in;
   logic [5:0]        group_ff, group_in;
   logic [T_W-1:0]    t_ff, t_in;
   logic [FULL_W-1:0] addr_ff, addr_in;
   logic [7:0]        x_ff, x_in;
   logic [1:0]        pix_ff, pix_in;
   logic              second_ff, second_in;

   logic              accept;
   logic [8:0]        line_gap;
   logic [10:0]       t_full;
   logic [FULL_W-1:0] cur_addr;
   logic              byte_ok;
   logic              advance;
   logic              ram_we, ram_re;
   logic [ADDR_W-1:0] ram_addr;
   logic [7:0]        ram_wdata, ram_rdata, merged;
   merge_ctl_type     mctl;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_CLEAR;
         clr_ff    <= '0;
         pix_ff    <= '0;
         second_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         clr_ff    <= clr_in;
         pix_ff    <= pix_in;
         second_ff <= second_in;
      end
   end

   always_ff @(posedge clock) begin
      raddr_ff  <= raddr_in;
      rd_ok_ff  <= rd_ok_in;
      shades_ff <= shades_in;
      group_ff  <= group_in;
      t_ff      <= t_in;
      addr_ff   <= addr_in;
      x_ff      <= x_in;
   end

   assign busy     = (state_ff != ST_IDLE);
   assign accept   = start && !busy;
   assign line_gap = 9'(LCD_LINES - 1) - {1'b0, req_line};
   assign t_full   = 11'(line_gap) * 11'd3;
   assign cur_addr = addr_ff + FULL_W'(second_ff);
   assign byte_ok  = (9'(x_ff) < 9'(LCD_PIXELS_PER_LINE))
                     && (32'(cur_addr) < 32'(STORE_BYTES));

   assign mctl.shade  = shades_ff[1:0];
   assign mctl.offset = t_ff[2:0];
   assign mctl.second = second_ff;

   always_comb begin
      state_in  = state_ff;
      clr_in    = clr_ff;
      raddr_in  = raddr_ff;
      rd_ok_in  = rd_ok_ff;
      shades_in = shades_ff;
      group_in  = group_ff;
      t_in      = t_ff;
      addr_in   = addr_ff;
      x_in      = x_ff;
      pix_in    = pix_ff;
      second_in = second_ff;
      advance   = 1'b0;
      ram_we    = 1'b0;
      ram_re    = 1'b0;
      ram_addr  = ADDR_W'(cur_addr);
      ram_wdata = merged;
      rsp_strobe    = 1'b0;
      rsp_read_data = 8'd0;

      case (state_ff)
         ST_CLEAR: begin
            ram_we    = 1'b1;
            ram_addr  = clr_ff;
            ram_wdata = 8'd0;
            clr_in    = clr_ff + ADDR_W'(1);
            if (32'(clr_ff) == 32'(STORE_BYTES - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (accept) begin
               raddr_in  = req_read_address;
               rd_ok_in  = 32'(req_read_address) < 32'(STORE_BYTES);
               shades_in = req_packed_pixels;
               group_in  = req_column_group;
               t_in      = T_W'(t_full);
               pix_in    = '0;
               second_in = 1'b0;
               if (req_kind == KIND_READ) begin
                  state_in = ST_READ;
               end else if (9'(req_line) < 9'(LCD_LINES)) begin
                  state_in = ST_SETUP;
               end
            end
         end
         ST_READ: begin
            ram_re   = rd_ok_ff;
            ram_addr = ADDR_W'(raddr_ff);
            state_in = ST_READ_WAIT;
         end
         ST_READ_WAIT: begin
            rsp_strobe    = 1'b1;
            rsp_read_data = rd_ok_ff ? ram_rdata : 8'd0;
            state_in      = ST_IDLE;
         end
         ST_SETUP: begin
            addr_in  = FULL_W'(group_ff * (4 * ROW_BYTES))
                       + FULL_W'(t_ff[T_W-1:3]);
            x_in     = {group_ff, 2'b00};
            state_in = ST_PIX_RD;
         end
         ST_PIX_RD: begin
            if (byte_ok) begin
               ram_re   = 1'b1;
               state_in = ST_PIX_WR;
            end else begin
               advance = 1'b1;
            end
         end
         ST_PIX_WR: begin
            ram_we  = 1'b1;
            advance = 1'b1;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      if (advance) begin
         if (!second_ff && (t_ff[2:0] >= SPILL_OFFSET)) begin
            second_in = 1'b1;
            state_in  = ST_PIX_RD;
         end else begin
            second_in = 1'b0;
            pix_in    = pix_ff + 2'd1;
            x_in      = x_ff + 8'd1;
            addr_in   = addr_ff + FULL_W'(ROW_BYTES);
            shades_in = shades_ff >> 2;
            state_in  = (pix_ff == 2'd3) ? ST_IDLE : ST_PIX_RD;
         end
      end
   end

   rdb_merge u_merge (
      .ctl   (mctl),
      .rdata (ram_rdata),
      .wdata (merged)
   );

   rdb_ram #(
      .WIDTH (8),
      .DEPTH (STORE_BYTES)
   ) u_store (
      .clock (clock),
      .we    (ram_we),
      .re    (ram_re),
      .addr  (ram_addr),
      .wdata (ram_wdata),
      .rdata (ram_rdata)
   );

   // single port: never a read and a write together
   a_port_excl: assert property (@(posedge clock) disable iff (reset)
      !(ram_we && ram_re))
      else $error("ram read and write in one cycle");

   a_rsp_single: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |=> !rsp_strobe)
      else $error("result strobe longer than one cycle");

   a_rsp_after_read: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(state_ff == ST_READ))
      else $error("result without a read access");

   // a merge write always follows the read of the same byte
   a_merge_read_first: assert property (@(posedge clock) disable iff (reset)
      (ram_we && state_ff == ST_PIX_WR) |-> $past(ram_re && state_ff == ST_PIX_RD))
      else $error("merge write without preceding read");

endmodule
